>>> hw/rtl/sts_pkg.sv
// Shared types and constants for the serial transaction supervisor.
// Depends on nothing; the supervisor, its step module and the bench import it.
package sts_pkg;

    localparam int TIMER_BITS = 8;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CMP_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TX_TIMEOUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_TIMEOUT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_COUNT_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_RX_LIMIT    = 2'd3;

    localparam logic [CFG_W-1:0] TX_TIMEOUT_RST     = 8'd10;
    localparam logic [CFG_W-1:0] RX_TIMEOUT_RST     = 8'd20;
    localparam logic [CFG_W-1:0] FAIL_COUNT_MAX_RST = 8'd10;
    localparam logic [CFG_W-1:0] NO_RX_LIMIT_RST    = 8'd3;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    typedef enum logic [1:0] {
        OUTER_IDLE = 2'b01,
        OUTER_RUN  = 2'b10
    } outer_phase_t;

    typedef enum logic [5:0] {
        INNER_START   = 6'b000001,
        INNER_TX_WAIT = 6'b000010,
        INNER_RX_WAIT = 6'b000100,
        INNER_TX_FAIL = 6'b001000,
        INNER_RX_FAIL = 6'b010000,
        INNER_FINISH  = 6'b100000
    } inner_phase_t;

    typedef struct packed {
        logic req_type;
        logic tx_busy;
        logic tx_more_data;
        logic tx_shift_empty;
        logic rx_frame_done;
        logic reply_ack_ok;
        logic reply_chk_ok;
    } sts_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] tx_timeout;
        logic [CFG_W-1:0] rx_timeout;
        logic [CFG_W-1:0] fail_count_max;
        logic [CFG_W-1:0] no_receiver_limit;
    } sts_cfg_t;

    typedef struct packed {
        outer_phase_t          outer_phase;
        inner_phase_t          inner_phase;
        logic [TIMER_BITS-1:0] tick_timer;
        logic                  transfer_active;
        logic                  transfer_ok;
        logic                  tx_timeout_flag;
        logic                  rx_timeout_flag;
        logic                  ack_flag;
        logic [CFG_W-1:0]      fail_counter;
        logic                  no_receiver_flag;
        logic                  error_flag;
    } sts_state_t;

    typedef struct packed {
        logic start_tx;
        logic stop_tx;
        logic reply_accept;
        logic round_done;
    } sts_pulse_t;

endpackage

>>> hw/rtl/sts_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing beyond the language; used by the top level.
interface sts_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic tx_busy;
    logic tx_more_data;
    logic tx_shift_empty;
    logic rx_frame_done;
    logic reply_ack_ok;
    logic reply_chk_ok;

    modport source (output valid, req_type, tx_busy, tx_more_data, tx_shift_empty,
                    rx_frame_done, reply_ack_ok, reply_chk_ok, input ready);
    modport sink   (input valid, req_type, tx_busy, tx_more_data, tx_shift_empty,
                    rx_frame_done, reply_ack_ok, reply_chk_ok, output ready);
endinterface

interface sts_res_if;
    logic       valid;
    logic       ready;
    logic       busy_res;
    logic       start_tx;
    logic       stop_tx;
    logic       reply_accept;
    logic       round_done;
    logic       tx_timed_out;
    logic       rx_timed_out;
    logic       acknowledged;
    logic [7:0] failure_count;
    logic       no_receiver;
    logic       link_error;
    logic [7:0] timer_value;

    modport source (output valid, busy_res, start_tx, stop_tx, reply_accept, round_done,
                    tx_timed_out, rx_timed_out, acknowledged, failure_count,
                    no_receiver, link_error, timer_value, input ready);
    modport sink   (input valid, busy_res, start_tx, stop_tx, reply_accept, round_done,
                    tx_timed_out, rx_timed_out, acknowledged, failure_count,
                    no_receiver, link_error, timer_value, output ready);
endinterface

>>> hw/rtl/serial_transaction_supervisor.sv
// Top level of the serial transaction supervisor: channels, registers, result stage.
// Depends on sts_pkg, the channel interfaces in sts_if and the sts_step module.
//
// Each item (a timer tick or a poll step) is taken into an input register, applied
// to the supervisor state as it moves on, and the result item lands in an output
// register. One item is accepted every cycle while the result stage is not held up
// by its consumer; items pass the input register, then the result register. The input
// register empties into the result register whenever that one is free or being read,
// so a new item is still taken while a finished result waits for its consumer.
// Configuration registers are written through cfg_we, cfg_index and cfg_data and
// must only change while no item is in flight.
module serial_transaction_supervisor
    import sts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sts_req_if.sink              req,
    sts_res_if.source            res
);

    sts_cfg_t   cfg_reg;
    sts_state_t state_reg;
    sts_state_t state_next;
    sts_pulse_t pulse;
    sts_item_t  item_reg;
    logic       item_valid_reg;
    logic       res_valid_reg;
    logic       advance;
    sts_state_t res_state_reg;
    sts_pulse_t res_pulse_reg;

    // The result register is free when empty or when its item leaves this cycle.
    assign advance   = !res_valid_reg || res.ready;
    assign req.ready = !item_valid_reg || advance;

    // Configuration registers, written one at a time by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tx_timeout        <= TX_TIMEOUT_RST;
            cfg_reg.rx_timeout        <= RX_TIMEOUT_RST;
            cfg_reg.fail_count_max    <= FAIL_COUNT_MAX_RST;
            cfg_reg.no_receiver_limit <= NO_RX_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TX_TIMEOUT:     cfg_reg.tx_timeout        <= cfg_data;
                CFG_RX_TIMEOUT:     cfg_reg.rx_timeout        <= cfg_data;
                CFG_FAIL_COUNT_MAX: cfg_reg.fail_count_max    <= cfg_data;
                CFG_NO_RX_LIMIT:    cfg_reg.no_receiver_limit <= cfg_data;
                default:            cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            item_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.req_type       <= req.req_type;
            item_reg.tx_busy        <= req.tx_busy;
            item_reg.tx_more_data   <= req.tx_more_data;
            item_reg.tx_shift_empty <= req.tx_shift_empty;
            item_reg.rx_frame_done  <= req.rx_frame_done;
            item_reg.reply_ack_ok   <= req.reply_ack_ok;
            item_reg.reply_chk_ok   <= req.reply_chk_ok;
        end
    end

    sts_step u_step (
        .cur   (state_reg),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .nxt   (state_next),
        .pulse (pulse)
    );

    // Supervisor state moves only when an item passes into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.outer_phase      <= OUTER_IDLE;
            state_reg.inner_phase      <= INNER_START;
            state_reg.tick_timer       <= '0;
            state_reg.transfer_active  <= 1'b0;
            state_reg.transfer_ok      <= 1'b0;
            state_reg.tx_timeout_flag  <= 1'b0;
            state_reg.rx_timeout_flag  <= 1'b0;
            state_reg.ack_flag         <= 1'b0;
            state_reg.fail_counter     <= '0;
            state_reg.no_receiver_flag <= 1'b0;
            state_reg.error_flag       <= 1'b0;
        end
        else if (item_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid_reg && advance)
        begin
            res_state_reg <= state_next;
            res_pulse_reg <= pulse;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.busy_res      = res_state_reg.transfer_active;
    assign res.start_tx      = res_pulse_reg.start_tx;
    assign res.stop_tx       = res_pulse_reg.stop_tx;
    assign res.reply_accept  = res_pulse_reg.reply_accept;
    assign res.round_done    = res_pulse_reg.round_done;
    assign res.tx_timed_out  = res_state_reg.tx_timeout_flag;
    assign res.rx_timed_out  = res_state_reg.rx_timeout_flag;
    assign res.acknowledged  = res_state_reg.ack_flag;
    assign res.failure_count = res_state_reg.fail_counter;
    assign res.no_receiver   = res_state_reg.no_receiver_flag;
    assign res.link_error    = res_state_reg.error_flag;
    assign res.timer_value   = 8'(res_state_reg.tick_timer);

endmodule

>>> hw/rtl/sts_step.sv
// Next-state logic of the supervisor: one tick or poll item applied to the state.
// Depends on sts_pkg for the state, item, configuration and pulse types.
module sts_step
    import sts_pkg::*;
(
    input  sts_state_t cur,
    input  sts_item_t  item,
    input  sts_cfg_t   cfg,
    output sts_state_t nxt,
    output sts_pulse_t pulse
);

    logic [CMP_W-1:0] timer_x;
    logic [CMP_W-1:0] tx_lim_x;
    logic [CMP_W-1:0] rx_lim_x;
    logic             tx_expired;
    logic             rx_pending;
    logic             timeout;
    logic             good_reply;
    logic [CFG_W-1:0] cnt_new;

    assign timer_x    = CMP_W'(cur.tick_timer);
    assign tx_lim_x   = CMP_W'(cfg.tx_timeout);
    assign rx_lim_x   = CMP_W'(cfg.rx_timeout);
    assign tx_expired = (timer_x > CMP_W'(1) && !item.tx_more_data) || (timer_x > tx_lim_x);
    // The receive wait entered straight from the transmit wait sees a cleared timer.
    assign rx_pending = (rx_lim_x != '0);
    assign timeout    = cur.tx_timeout_flag || cur.rx_timeout_flag;
    assign good_reply = cur.transfer_ok && item.reply_ack_ok && item.reply_chk_ok;

    always_comb
    begin
        if (!timeout)
        begin
            cnt_new = '0;
        end
        else if (cur.fail_counter < cfg.fail_count_max)
        begin
            cnt_new = cur.fail_counter + CFG_W'(1);
        end
        else
        begin
            cnt_new = cur.fail_counter;
        end
    end

    always_comb
    begin
        nxt   = cur;
        pulse = '0;
        if (!item.req_type)
        begin
            if (cur.tick_timer != TIMER_MAX)
            begin
                nxt.tick_timer = cur.tick_timer + TIMER_BITS'(1);
            end
        end
        else if (cur.outer_phase != OUTER_RUN)
        begin
            nxt.transfer_active = 1'b1;
            nxt.outer_phase     = OUTER_RUN;
            nxt.tick_timer      = '0;
            nxt.inner_phase     = INNER_TX_WAIT;
            pulse.start_tx      = 1'b1;
        end
        else if (cur.transfer_active)
        begin
            case (cur.inner_phase)
                INNER_START:
                begin
                    nxt.tick_timer  = '0;
                    nxt.inner_phase = INNER_TX_WAIT;
                    pulse.start_tx  = 1'b1;
                end
                INNER_TX_WAIT:
                begin
                    if (item.tx_busy)
                    begin
                        if (tx_expired)
                        begin
                            nxt.inner_phase = INNER_TX_FAIL;
                        end
                    end
                    else
                    begin
                        nxt.tx_timeout_flag = 1'b0;
                        if (item.tx_shift_empty)
                        begin
                            pulse.stop_tx  = 1'b1;
                            nxt.tick_timer = '0;
                            if (item.rx_frame_done)
                            begin
                                nxt.transfer_ok     = 1'b1;
                                nxt.rx_timeout_flag = 1'b0;
                                nxt.inner_phase     = INNER_FINISH;
                            end
                            else if (rx_pending)
                            begin
                                nxt.inner_phase = INNER_RX_WAIT;
                            end
                            else
                            begin
                                nxt.inner_phase = INNER_RX_FAIL;
                            end
                        end
                    end
                end
                INNER_RX_WAIT:
                begin
                    if (item.rx_frame_done)
                    begin
                        nxt.transfer_ok     = 1'b1;
                        nxt.tx_timeout_flag = 1'b0;
                        nxt.rx_timeout_flag = 1'b0;
                        nxt.inner_phase     = INNER_FINISH;
                    end
                    else if (timer_x >= rx_lim_x)
                    begin
                        nxt.inner_phase = INNER_RX_FAIL;
                    end
                end
                INNER_TX_FAIL:
                begin
                    nxt.tx_timeout_flag = 1'b1;
                    nxt.transfer_ok     = 1'b0;
                    nxt.inner_phase     = INNER_FINISH;
                    pulse.stop_tx       = 1'b1;
                end
                INNER_RX_FAIL:
                begin
                    nxt.rx_timeout_flag = 1'b1;
                    nxt.transfer_ok     = 1'b0;
                    nxt.transfer_active = 1'b0;
                    nxt.inner_phase     = INNER_START;
                end
                default:
                begin
                    nxt.transfer_active = 1'b0;
                    nxt.inner_phase     = INNER_START;
                end
            endcase
        end
        else
        begin
            pulse.round_done = 1'b1;
            nxt.outer_phase  = OUTER_IDLE;
            if (good_reply)
            begin
                nxt.fail_counter     = '0;
                nxt.no_receiver_flag = 1'b0;
                nxt.ack_flag         = 1'b1;
                pulse.reply_accept   = 1'b1;
            end
            else
            begin
                nxt.ack_flag         = 1'b0;
                nxt.fail_counter     = cnt_new;
                nxt.no_receiver_flag = cnt_new > cfg.no_receiver_limit;
                nxt.error_flag       = timeout;
            end
        end
    end

endmodule

>>> bench/serial_transaction_supervisor_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for serial_transaction_supervisor: directed and random ticks and polls,
// each result checked against a predictor of the transaction sequence kept in this file.
// Depends on sts_pkg, the channel interfaces in sts_if and the supervisor top level.
module serial_transaction_supervisor_tb;
    import sts_pkg::*;

    localparam int CLK_HALF_NS  = 2;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_WAIT     = 16;
    localparam int RANDOM_ITEMS = 1850;
    localparam int PHASES       = 9;
    localparam int DRAIN_CYCLES = 10;
    localparam int RUN_LIMIT_NS = 2_000_000;

    // One status item as the supervisor reports it after each tick or poll.
    typedef struct packed {
        logic       busy;
        logic       start_tx;
        logic       stop_tx;
        logic       reply_accept;
        logic       round_done;
        logic       tx_timed_out;
        logic       rx_timed_out;
        logic       acknowledged;
        logic [7:0] failure_count;
        logic       no_receiver;
        logic       link_error;
        logic [7:0] timer_value;
    } sup_status_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    sts_req_if req_ch();
    sts_res_if res_ch();

    serial_transaction_supervisor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // Requests waiting to be driven, and the status items predicted for requests that the
    // block has already taken, oldest first.
    sts_item_t   queued_requests[$];
    sup_status_t predicted_status[$];

    int requests_sent   = 0;
    int requests_taken  = 0;
    int status_taken    = 0;
    int status_paced    = 0;
    int stimulus_total  = 0;
    int mismatch_count  = 0;
    int send_gap        = 0;
    int sink_stall      = 0;
    bit sender_calm     = 1'b0;
    bit sink_calm       = 1'b1;

    // ------------------------------------------------------------------------------------
    // Predictor. It mirrors the supervisor state and the register file; the register copy
    // is updated whenever the bench writes a register, which only happens while idle.
    // ------------------------------------------------------------------------------------
    sts_cfg_t link_cfg = '{tx_timeout: TX_TIMEOUT_RST, rx_timeout: RX_TIMEOUT_RST,
                           fail_count_max: FAIL_COUNT_MAX_RST,
                           no_receiver_limit: NO_RX_LIMIT_RST};

    outer_phase_t          sup_outer  = OUTER_IDLE;
    inner_phase_t          sup_inner  = INNER_START;
    logic [TIMER_BITS-1:0] sup_timer  = '0;
    logic [CFG_W-1:0]      sup_fail   = '0;
    logic                  sup_active = 1'b0;
    logic                  sup_ok     = 1'b0;
    logic                  sup_tx_to  = 1'b0;
    logic                  sup_rx_to  = 1'b0;
    logic                  sup_ack    = 1'b0;
    logic                  sup_norx   = 1'b0;
    logic                  sup_err    = 1'b0;

    // Receive wait. A frame ends the transfer well and clears both timeout flags. Without a
    // frame the block keeps waiting while the timer is under the limit; once it is not, the
    // next poll reports the receive timeout.
    function automatic void await_reply(logic frame_done);
        if (frame_done)
        begin
            sup_ok    = 1'b1;
            sup_tx_to = 1'b0;
            sup_rx_to = 1'b0;
            sup_inner = INNER_FINISH;
        end
        else if (int'(sup_timer) >= int'(link_cfg.rx_timeout))
        begin
            sup_inner = INNER_RX_FAIL;
        end
    endfunction

    // Applies one accepted request to the mirrored state and returns the status item that
    // the block must report for it.
    function automatic sup_status_t advance_supervisor(sts_item_t it);
        sup_status_t status;
        logic        fired_start;
        logic        fired_stop;
        logic        fired_accept;
        logic        fired_done;
        logic        timed_out;

        fired_start  = 1'b0;
        fired_stop   = 1'b0;
        fired_accept = 1'b0;
        fired_done   = 1'b0;

        if (!it.req_type)
        begin
            // A tick only moves the timer, which sticks at its top value.
            if (sup_timer != TIMER_MAX)
                sup_timer++;
        end
        else if (sup_outer != OUTER_RUN)
        begin
            // The first poll of a round only enables the transmitter.
            sup_active  = 1'b1;
            sup_outer   = OUTER_RUN;
            fired_start = 1'b1;
            sup_timer   = '0;
            sup_inner   = INNER_TX_WAIT;
        end
        else if (sup_active)
        begin
            case (sup_inner)
                INNER_START:
                begin
                    fired_start = 1'b1;
                    sup_timer   = '0;
                    sup_inner   = INNER_TX_WAIT;
                end
                INNER_TX_WAIT:
                begin
                    if (it.tx_busy)
                    begin
                        // A transmitter that stays busy with nothing left to send, or past
                        // the configured limit, has hung.
                        if ((int'(sup_timer) > 1 && !it.tx_more_data)
                            || int'(sup_timer) > int'(link_cfg.tx_timeout))
                            sup_inner = INNER_TX_FAIL;
                    end
                    else
                    begin
                        sup_tx_to = 1'b0;
                        if (it.tx_shift_empty)
                        begin
                            fired_stop = 1'b1;
                            sup_timer  = '0;
                            sup_inner  = INNER_RX_WAIT;
                            await_reply(it.rx_frame_done);
                        end
                    end
                end
                INNER_RX_WAIT:
                begin
                    await_reply(it.rx_frame_done);
                end
                INNER_TX_FAIL:
                begin
                    sup_tx_to  = 1'b1;
                    sup_ok     = 1'b0;
                    fired_stop = 1'b1;
                    sup_inner  = INNER_FINISH;
                end
                INNER_RX_FAIL:
                begin
                    sup_rx_to  = 1'b1;
                    sup_ok     = 1'b0;
                    sup_active = 1'b0;
                    sup_inner  = INNER_START;
                end
                default:
                begin
                    sup_active = 1'b0;
                    sup_inner  = INNER_START;
                end
            endcase
        end
        else
        begin
            // Judging the finished transfer closes the round either way.
            fired_done = 1'b1;
            sup_outer  = OUTER_IDLE;
            if (sup_ok && it.reply_ack_ok && it.reply_chk_ok)
            begin
                sup_fail     = '0;
                sup_norx     = 1'b0;
                sup_ack      = 1'b1;
                fired_accept = 1'b1;
            end
            else
            begin
                // A timeout flag left over from an earlier round still counts here.
                timed_out = sup_tx_to || sup_rx_to;
                sup_ack   = 1'b0;
                if (!timed_out)
                    sup_fail = '0;
                else if (sup_fail < link_cfg.fail_count_max)
                    sup_fail++;
                sup_norx = sup_fail > link_cfg.no_receiver_limit;
                sup_err  = timed_out;
            end
        end

        status.busy          = sup_active;
        status.start_tx      = fired_start;
        status.stop_tx       = fired_stop;
        status.reply_accept  = fired_accept;
        status.round_done    = fired_done;
        status.tx_timed_out  = sup_tx_to;
        status.rx_timed_out  = sup_rx_to;
        status.acknowledged  = sup_ack;
        status.failure_count = sup_fail;
        status.no_receiver   = sup_norx;
        status.link_error    = sup_err;
        status.timer_value   = 8'(sup_timer);
        return status;
    endfunction

    // ------------------------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("status item %0d, %s is %0d, expected %0d",
                                      status_taken, name, got, want));
    endtask

    task automatic compare_status(sup_status_t got, sup_status_t want);
        check_field("busy_res",      got.busy,          want.busy);
        check_field("start_tx",      got.start_tx,      want.start_tx);
        check_field("stop_tx",       got.stop_tx,       want.stop_tx);
        check_field("reply_accept",  got.reply_accept,  want.reply_accept);
        check_field("round_done",    got.round_done,    want.round_done);
        check_field("tx_timed_out",  got.tx_timed_out,  want.tx_timed_out);
        check_field("rx_timed_out",  got.rx_timed_out,  want.rx_timed_out);
        check_field("acknowledged",  got.acknowledged,  want.acknowledged);
        check_field("failure_count", got.failure_count, want.failure_count);
        check_field("no_receiver",   got.no_receiver,   want.no_receiver);
        check_field("link_error",    got.link_error,    want.link_error);
        check_field("timer_value",   got.timer_value,   want.timer_value);
    endtask

    // Idle time for one item: none during a calm stretch, otherwise drawn from zero to MAX_WAIT.
    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // ------------------------------------------------------------------------------------
    // Request driver. Inputs change on the falling edge only. An item stays on the channel
    // until the monitor has seen it taken; then the gap drawn for it runs out with valid
    // low before the next item goes out. A zero gap keeps valid high without a dip.
    // ------------------------------------------------------------------------------------
    always @(negedge clk)
    begin
        sts_item_t next_item;

        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && requests_taken != requests_sent)
        begin
            // The current item has not been taken yet; hold it.
        end
        else if (send_gap > 0)
        begin
            req_ch.valid <= 1'b0;
            send_gap--;
        end
        else if (queued_requests.size() != 0)
        begin
            next_item = queued_requests.pop_front();
            req_ch.req_type       <= next_item.req_type;
            req_ch.tx_busy        <= next_item.tx_busy;
            req_ch.tx_more_data   <= next_item.tx_more_data;
            req_ch.tx_shift_empty <= next_item.tx_shift_empty;
            req_ch.rx_frame_done  <= next_item.rx_frame_done;
            req_ch.reply_ack_ok   <= next_item.reply_ack_ok;
            req_ch.reply_chk_ok   <= next_item.reply_chk_ok;
            req_ch.valid          <= 1'b1;
            requests_sent++;
            if ($urandom_range(0, 39) == 0)
                sender_calm = !sender_calm;
            send_gap = draw_wait(sender_calm);
        end
        else
        begin
            req_ch.valid <= 1'b0;
        end
    end

    // Status sink. After each item it takes, it draws a stall and holds ready low until it runs out.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (status_paced != status_taken)
            begin
                status_paced = status_taken;
                if ($urandom_range(0, 39) == 0)
                    sink_calm = !sink_calm;
                sink_stall = draw_wait(sink_calm);
            end
            if (sink_stall > 0)
            begin
                res_ch.ready <= 1'b0;
                sink_stall--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Monitor. Both channels are sampled on the rising edge, where a handshake completes.
    // A taken request is run through the predictor at once; a taken status item is checked
    // against the oldest prediction.
    // ------------------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sts_item_t   taken;
        sup_status_t got;

        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken.req_type       = req_ch.req_type;
                taken.tx_busy        = req_ch.tx_busy;
                taken.tx_more_data   = req_ch.tx_more_data;
                taken.tx_shift_empty = req_ch.tx_shift_empty;
                taken.rx_frame_done  = req_ch.rx_frame_done;
                taken.reply_ack_ok   = req_ch.reply_ack_ok;
                taken.reply_chk_ok   = req_ch.reply_chk_ok;
                predicted_status.push_back(advance_supervisor(taken));
                requests_taken++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.busy          = res_ch.busy_res;
                got.start_tx      = res_ch.start_tx;
                got.stop_tx       = res_ch.stop_tx;
                got.reply_accept  = res_ch.reply_accept;
                got.round_done    = res_ch.round_done;
                got.tx_timed_out  = res_ch.tx_timed_out;
                got.rx_timed_out  = res_ch.rx_timed_out;
                got.acknowledged  = res_ch.acknowledged;
                got.failure_count = res_ch.failure_count;
                got.no_receiver   = res_ch.no_receiver;
                got.link_error    = res_ch.link_error;
                got.timer_value   = res_ch.timer_value;
                if (predicted_status.size() == 0)
                    report_mismatch($sformatf("status item %0d with no request waiting",
                                              status_taken));
                else
                    compare_status(got, predicted_status.pop_front());
                status_taken++;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus helpers. Polls take their six flag bits in the order busy, more data,
    // shifter empty, frame done, ack ok, checksum ok.
    // ------------------------------------------------------------------------------------
    function automatic logic chance(int percent);
        return $urandom_range(0, 99) < percent;
    endfunction

    task automatic queue_item(sts_item_t it);
        queued_requests.push_back(it);
        stimulus_total++;
    endtask

    // Ticks carry random payload bits, which the block must ignore.
    task automatic queue_ticks(int count);
        sts_item_t it;

        repeat (count)
        begin
            it          = $bits(sts_item_t)'($urandom);
            it.req_type = 1'b0;
            queue_item(it);
        end
    endtask

    task automatic queue_poll(logic [5:0] flags);
        queue_item({1'b1, flags});
    endtask

    // One transaction round with random content. Tick counts are sized from the current
    // register values so that both timeout paths and the good path are all reached; a
    // round can still drift out of step when a random tick trips a short timeout early.
    task automatic queue_round();
        int   rx_polls;
        logic frame_now;

        rx_polls = $urandom_range(0, 3);
        queue_poll(6'($urandom));
        repeat ($urandom_range(0, 3))
        begin
            queue_ticks($urandom_range(0, 2));
            queue_poll({1'b1, chance(80), 4'($urandom)});
        end
        if (chance(20))
        begin
            // The transmitter hangs: busy past the limit with data, or busy with none left.
            if (link_cfg.tx_timeout < 8'd40 && chance(50))
            begin
                queue_ticks(int'(link_cfg.tx_timeout) + 2);
                queue_poll({2'b11, 4'($urandom)});
            end
            else
            begin
                queue_ticks(2);
                queue_poll({2'b10, 4'($urandom)});
            end
            queue_poll(6'($urandom));
            queue_poll(6'($urandom));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                queue_poll({1'b0, chance(50), 1'b0, 3'($urandom)});
            frame_now = chance(30);
            queue_poll({1'b0, chance(50), 1'b1, frame_now, 2'($urandom)});
            if (!frame_now)
            begin
                repeat (rx_polls)
                begin
                    queue_ticks($urandom_range(0, 3));
                    queue_poll({3'($urandom), chance(25), 2'($urandom)});
                end
                if (chance(35) && (link_cfg.rx_timeout < 8'd40 || chance(10)))
                begin
                    // No reply at all: run the timer past the receive limit.
                    queue_ticks(int'(link_cfg.rx_timeout) + 1);
                    queue_poll({3'($urandom), 1'b0, 2'($urandom)});
                end
                else
                begin
                    queue_poll({3'($urandom), 1'b1, 2'($urandom)});
                end
            end
            queue_poll(6'($urandom));
        end
        // The judging poll, mostly with a good ack and checksum.
        queue_poll({4'($urandom), chance(80), chance(80)});
    endtask

    // Waits until every queued request has been taken and every status item checked.
    task automatic wait_for_idle();
        while (queued_requests.size() != 0 || requests_taken != requests_sent
               || predicted_status.size() != 0)
            @(negedge clk);
    endtask

    task automatic program_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (index)
            CFG_TX_TIMEOUT:     link_cfg.tx_timeout        = value;
            CFG_RX_TIMEOUT:     link_cfg.rx_timeout        = value;
            CFG_FAIL_COUNT_MAX: link_cfg.fail_count_max    = value;
            CFG_NO_RX_LIMIT:    link_cfg.no_receiver_limit = value;
            default:            ;
        endcase
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] tx_limit, logic [CFG_W-1:0] rx_limit,
                                  logic [CFG_W-1:0] count_max, logic [CFG_W-1:0] norx_limit);
        program_register(CFG_TX_TIMEOUT, tx_limit);
        program_register(CFG_RX_TIMEOUT, rx_limit);
        program_register(CFG_FAIL_COUNT_MAX, count_max);
        program_register(CFG_NO_RX_LIMIT, norx_limit);
    endtask

    // Mostly well-formed rounds, with short bursts of fully random items in between. The
    // phase ends by waiting until every status item has come back.
    task automatic run_random_phase();
        int target;

        target = stimulus_total + RANDOM_ITEMS / PHASES;
        while (stimulus_total < target)
        begin
            if (chance(12))
                repeat ($urandom_range(1, 6))
                    queue_item($bits(sts_item_t)'($urandom));
            else
                queue_round();
        end
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------------------
    initial
    begin
        req_ch.valid          = 1'b0;
        req_ch.req_type       = 1'b0;
        req_ch.tx_busy        = 1'b0;
        req_ch.tx_more_data   = 1'b0;
        req_ch.tx_shift_empty = 1'b0;
        req_ch.rx_frame_done  = 1'b0;
        req_ch.reply_ack_ok   = 1'b0;
        req_ch.reply_chk_ok   = 1'b0;
        res_ch.ready          = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rounds under the reset register values.
        queue_item(7'b0000000);     // tick with every payload bit low
        queue_item(7'b0111111);     // tick with every payload bit high, all ignored
        queue_poll(6'b111111);      // opens a round: only start_tx
        queue_poll(6'b110000);      // busy with data left at timer 0: keep waiting
        queue_ticks(2);
        queue_poll(6'b110000);      // timer 2, data left, under the limit: keep waiting
        queue_poll(6'b000000);      // transmitter done but shifter still full
        queue_poll(6'b001100);      // shifter empty and the frame is already there
        queue_poll(6'b000000);      // transfer closes
        queue_poll(6'b000011);      // good ack and checksum: reply accepted
        queue_poll(6'b000000);      // next round opens
        queue_ticks(2);
        queue_poll(6'b100000);      // busy with nothing left after two ticks: hung
        queue_poll(6'b000000);      // transmit timeout raised, stop_tx
        queue_poll(6'b000000);      // transfer closes
        queue_poll(6'b000011);      // timed out round: counter rises, link error
        queue_poll(6'b000000);      // next round opens
        queue_poll(6'b001000);      // stale transmit flag clears; no frame yet
        queue_poll(6'b100100);      // frame arrives, busy no longer matters
        queue_poll(6'b000000);      // transfer closes
        queue_poll(6'b000010);      // bad checksum without timeout: counter clears
        queue_poll(6'b000000);      // next round opens
        queue_poll(6'b011111);      // frame at once, with data bits high
        queue_poll(6'b000000);      // transfer closes
        queue_poll(6'b000001);      // bad ack
        wait_for_idle();

        // Register extremes first, then small limits where timeouts and saturation are
        // frequent, one fully random setting, and the reset values written back at the end.
        apply_settings(8'd0, 8'd0, 8'd0, 8'd0);
        run_random_phase();

        apply_settings(8'd255, 8'd255, 8'd255, 8'd255);
        queue_ticks(260);           // the tick timer has to stick at its top value
        run_random_phase();

        repeat (PHASES - 4)
        begin
            apply_settings(8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                           8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)));
            run_random_phase();
        end

        apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random_phase();

        apply_settings(TX_TIMEOUT_RST, RX_TIMEOUT_RST, FAIL_COUNT_MAX_RST, NO_RX_LIMIT_RST);
        run_random_phase();

        // Leave room for any status item the block should not have produced.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog for a block that stops taking requests or stops reporting.
    initial
    begin
        #(RUN_LIMIT_NS * 1ns);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
